### rtl/hsl_pkg.sv
`timescale 1ns / 1ps
// hsl_pkg: shared types and constants for the hsl to rgb converter
// no dependencies

package hsl_pkg;

    // hue units: 1/16 degree, 5760 units per turn, 960 per sector
    localparam int unsigned HUE_FULL   = 5760;
    localparam int unsigned HUE_SECTOR = 960;
    // six turns, lifts any 16-bit signed hue into positive range
    localparam int unsigned HUE_BIAS   = 34560;
    // ceil(2^16 / 45), exact quotient for (u >> 7) / 45 over the hue range
    localparam int unsigned HUE_RECIP  = 1457;

    localparam int unsigned IN_BITS  = 56;
    localparam int unsigned OUT_BITS = 24;

    // sector names: dominant channel first, then the channel carrying x
    typedef enum logic [2:0] {
        SEC_RG = 3'd0,
        SEC_GR = 3'd1,
        SEC_GB = 3'd2,
        SEC_BG = 3'd3,
        SEC_BR = 3'd4,
        SEC_RB = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector     sector;
        logic [9:0]  w;       // 960 - |(hue mod 1920) - 960|
    } t_hue;

endpackage

### rtl/hsl_hue.sv
`timescale 1ns / 1ps
// hsl_hue: two-stage hue wrap, sector pick and triangle weight
// depends on hsl_pkg

module hsl_hue (
    input  logic          i_clk,
    input  logic          i_ce,
    input  logic [15:0]   i_hue,
    output hsl_pkg::t_hue o_hue
);
    import hsl_pkg::*;

    logic [16:0] n_u;
    logic [20:0] n_qprod;
    logic [16:0] r_u;
    logic [3:0]  r_q;

    logic [16:0] n_qm;
    logic [12:0] n_hw;
    logic [10:0] n_p;
    logic [9:0]  n_d;
    t_hue        n_hue;
    t_hue        r_hue;

    // stage 1: bias to positive and estimate turn count
    assign n_u     = {i_hue[15], i_hue} + 17'(HUE_BIAS);
    assign n_qprod = 21'(n_u[16:7]) * 21'(HUE_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_u <= n_u;
            r_q <= n_qprod[19:16];
        end
    end

    // stage 2: remainder, sector and weight
    assign n_qm = 17'(r_q) * 17'(HUE_FULL);
    assign n_hw = 13'(r_u - n_qm);

    always_comb begin
        if (n_hw < 13'(HUE_SECTOR)) begin
            n_hue.sector = SEC_RG;
        end else if (n_hw < 13'(2 * HUE_SECTOR)) begin
            n_hue.sector = SEC_GR;
        end else if (n_hw < 13'(3 * HUE_SECTOR)) begin
            n_hue.sector = SEC_GB;
        end else if (n_hw < 13'(4 * HUE_SECTOR)) begin
            n_hue.sector = SEC_BG;
        end else if (n_hw < 13'(5 * HUE_SECTOR)) begin
            n_hue.sector = SEC_BR;
        end else begin
            n_hue.sector = SEC_RB;
        end

        if (n_hw >= 13'(4 * HUE_SECTOR)) begin
            n_p = 11'(n_hw - 13'(4 * HUE_SECTOR));
        end else if (n_hw >= 13'(2 * HUE_SECTOR)) begin
            n_p = 11'(n_hw - 13'(2 * HUE_SECTOR));
        end else begin
            n_p = 11'(n_hw);
        end

        if (n_p >= 11'(HUE_SECTOR)) begin
            n_d = 10'(n_p - 11'(HUE_SECTOR));
        end else begin
            n_d = 10'(11'(HUE_SECTOR) - n_p);
        end
        n_hue.w = 10'(HUE_SECTOR) - n_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_hue <= n_hue;
        end
    end

    assign o_hue = r_hue;

endmodule

### rtl/hsl_chan.sv
`timescale 1ns / 1ps
// hsl_chan: one output channel, offset add, scale by 255, truncate and clamp
// depends on hsl_pkg

module hsl_chan #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_ce,
    input  logic signed [FRACTION_BITS+3:0] i_comp,
    input  logic signed [FRACTION_BITS+3:0] i_m,
    output logic [7:0]                     o_chan
);
    import hsl_pkg::*;

    localparam int CW  = FRACTION_BITS + 4;
    localparam int SUW = FRACTION_BITS + 5;
    localparam int PW  = FRACTION_BITS + 13;

    logic signed [SUW-1:0] n_sum;
    logic signed [PW-1:0]  n_sum_x;
    logic signed [PW-1:0]  n_p255;
    logic signed [PW-1:0]  r_p255;

    assign n_sum   = SUW'(i_comp) + SUW'(i_m);
    assign n_sum_x = PW'(n_sum);
    // x * 255 as x * 256 - x
    assign n_p255  = (n_sum_x <<< 8) - n_sum_x;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p255 <= n_p255;
        end
    end

    // negative truncates to at most zero, so it clamps to zero
    always_comb begin
        if (r_p255[PW-1]) begin
            o_chan = 8'd0;
        end else if (|r_p255[PW-2:FRACTION_BITS+8]) begin
            o_chan = 8'hff;
        end else begin
            o_chan = r_p255[FRACTION_BITS+7:FRACTION_BITS];
        end
    end

    // keeps the channel width tied to the chroma width
    if (CW != SUW - 1) begin : g_width_guard
        $error("hsl_chan width mismatch");
    end

endmodule

### rtl/hsl_to_rgb.sv
`timescale 1ns / 1ps
// hsl_to_rgb: hsl color to 8-bit rgb, nine register stages, one pixel per clock
// pipeline: 9 register stages, the result is offered from the output register
// throughput: one request per clock in every stage unless the output is held
// stall: a held output freezes the whole pipe, nothing lost or repeated
// reset: i_rst_n synchronous active low clears the valid bits only
// depends on hsl_pkg, hsl_hue, hsl_chan

module hsl_to_rgb #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // hue[15:0] saturation[32:16] lightness[49:33], zero pad [55:50]
    input  logic [hsl_pkg::IN_BITS-1:0]   i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // red[7:0] green[15:8] blue[23:16]
    output logic [hsl_pkg::OUT_BITS-1:0]  o_m_tdata
);
    import hsl_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int STAGES = 9;
    localparam int UP     = (F >= 16) ? F - 16 : 0;
    localparam int DN     = (F < 16) ? 16 - F : 0;
    localparam int SW     = F + 1;          // scaled s and l
    localparam int AW     = F + 3;          // 2l - one and one - t
    localparam int PW     = AW + SW + 1;    // (one - t) * s
    localparam int CW     = F + 4;          // chroma and x
    localparam int MW     = F + 4;          // offset m
    localparam int XW     = CW + 11;        // c * w
    localparam int VW     = F + 6;          // |c * w| / 64
    localparam int K      = VW + 4;         // reciprocal shift for / 15
    localparam int RW     = 2 * VW + 1;

    localparam logic signed [AW-1:0] ONE_A  = AW'(1) << F;
    localparam logic signed [PW-1:0] BIAS_C = (PW'(1) << F) - PW'(1);
    localparam logic signed [CW-1:0] C_ONE  = CW'(1);
    localparam logic signed [CW-1:0] C_ZERO = CW'(0);
    localparam logic [VW:0]          RECIP  = (VW+1)'((64'd1 << K) / 15);

    // global advance: the pipe moves unless the output register is held
    logic ce;
    logic [STAGES-1:0] r_v;

    assign ce         = ~r_v[STAGES-1] | i_m_tready;
    assign o_s_tready = ce;
    assign o_m_tvalid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (ce) begin
            r_v <= {r_v[STAGES-2:0], i_s_tvalid};
        end
    end

    // ---------------- stage 1: scale s, l and form one - |2l - one|
    logic [15:0]          in_hue;
    logic [16:0]          in_sat;
    logic [16:0]          in_lit;
    logic [16+UP:0]       n_s_up;
    logic [16+UP:0]       n_l_up;
    logic [SW-1:0]        n_s;
    logic [SW-1:0]        n_l;
    logic signed [AW-1:0] n_diff;
    logic signed [AW-1:0] n_t;
    logic signed [AW-1:0] r_a1;
    logic [SW-1:0]        r_s1;
    logic [SW-1:0]        r_l1;

    assign in_hue = i_s_tdata[15:0];
    assign in_sat = i_s_tdata[32:16];
    assign in_lit = i_s_tdata[49:33];

    assign n_s_up = (17+UP)'(in_sat) << UP;
    assign n_l_up = (17+UP)'(in_lit) << UP;
    assign n_s    = SW'(n_s_up >> DN);
    assign n_l    = SW'(n_l_up >> DN);
    assign n_diff = signed'(AW'({n_l, 1'b0})) - ONE_A;
    assign n_t    = n_diff[AW-1] ? -n_diff : n_diff;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a1 <= ONE_A - n_t;
            r_s1 <= n_s;
            r_l1 <= n_l;
        end
    end

    // hue path runs beside stages 1 and 2
    t_hue hue2;

    hsl_hue u_hue (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_hue (in_hue),
        .o_hue (hue2)
    );

    // ---------------- stage 2: (one - t) * s
    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] r_prod2;
    logic [SW-1:0]        r_l2;

    assign n_prod = PW'(r_a1) * PW'(signed'({1'b0, r_s1}));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_prod2 <= n_prod;
            r_l2    <= r_l1;
        end
    end

    // ---------------- stage 3: chroma, divide by one toward zero
    logic signed [PW-1:0] n_adj;
    logic signed [CW-1:0] r_c3;
    logic [SW-1:0]        r_l3;
    t_hue                 r_hue3;

    assign n_adj = r_prod2 + (r_prod2[PW-1] ? BIAS_C : '0);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c3   <= CW'(n_adj >>> F);
            r_l3   <= r_l2;
            r_hue3 <= hue2;
        end
    end

    // ---------------- stage 4: c * w and offset m = l - c/2
    logic signed [XW-1:0] n_cw;
    logic signed [CW-1:0] n_cadj;
    logic signed [CW-1:0] n_half;
    logic signed [XW-1:0] r_cw4;
    logic signed [CW-1:0] r_c4;
    logic signed [MW-1:0] r_m4;
    t_sector              r_sec4;

    assign n_cw   = XW'(r_c3) * XW'(signed'({1'b0, r_hue3.w}));
    assign n_cadj = r_c3 + (r_c3[CW-1] ? C_ONE : C_ZERO);
    assign n_half = n_cadj >>> 1;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cw4  <= n_cw;
            r_c4   <= r_c3;
            r_m4   <= MW'(signed'({1'b0, r_l3})) - MW'(n_half);
            r_sec4 <= r_hue3.sector;
        end
    end

    // ---------------- stage 5: magnitude, drop the factor 64 of 960
    logic [XW-1:0]        n_mag;
    logic                 r_neg5;
    logic [VW-1:0]        r_v5;
    logic signed [CW-1:0] r_c5;
    logic signed [MW-1:0] r_m5;
    t_sector              r_sec5;

    assign n_mag = r_cw4[XW-1] ? XW'(-r_cw4) : XW'(r_cw4);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_neg5 <= r_cw4[XW-1];
            r_v5   <= VW'(n_mag >> 6);
            r_c5   <= r_c4;
            r_m5   <= r_m4;
            r_sec5 <= r_sec4;
        end
    end

    // ---------------- stage 6: reciprocal multiply for / 15
    logic [RW-1:0]        r_vr6;
    logic [VW-1:0]        r_v6;
    logic                 r_neg6;
    logic signed [CW-1:0] r_c6;
    logic signed [MW-1:0] r_m6;
    t_sector              r_sec6;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_vr6  <= RW'(r_v5) * RW'(RECIP);
            r_v6   <= r_v5;
            r_neg6 <= r_neg5;
            r_c6   <= r_c5;
            r_m6   <= r_m5;
            r_sec6 <= r_sec5;
        end
    end

    // ---------------- stage 7: quotient fix-up and sign of x
    logic [VW-1:0]        n_qa;
    logic [VW+3:0]        n_q15;
    logic [VW+3:0]        n_rem;
    logic [VW-1:0]        n_q;
    logic signed [VW:0]   n_qs;
    logic signed [CW-1:0] r_x7;
    logic signed [CW-1:0] r_c7;
    logic signed [MW-1:0] r_m7;
    t_sector              r_sec7;

    // estimate is low by at most one
    assign n_qa  = VW'(r_vr6 >> K);
    assign n_q15 = ((VW+4)'(n_qa) << 4) - (VW+4)'(n_qa);
    assign n_rem = (VW+4)'(r_v6) - n_q15;
    assign n_q   = (n_rem >= (VW+4)'(15)) ? n_qa + VW'(1) : n_qa;
    assign n_qs  = signed'({1'b0, n_q});

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x7   <= CW'(r_neg6 ? -n_qs : n_qs);
            r_c7   <= r_c6;
            r_m7   <= r_m6;
            r_sec7 <= r_sec6;
        end
    end

    // ---------------- stage 8: sector permutation, scale (inside hsl_chan)
    logic signed [CW-1:0] n_r;
    logic signed [CW-1:0] n_g;
    logic signed [CW-1:0] n_b;
    logic [7:0]           red8;
    logic [7:0]           grn8;
    logic [7:0]           blu8;

    always_comb begin
        case (r_sec7)
            SEC_RG: begin n_r = r_c7;  n_g = r_x7;  n_b = '0;    end
            SEC_GR: begin n_r = r_x7;  n_g = r_c7;  n_b = '0;    end
            SEC_GB: begin n_r = '0;    n_g = r_c7;  n_b = r_x7;  end
            SEC_BG: begin n_r = '0;    n_g = r_x7;  n_b = r_c7;  end
            SEC_BR: begin n_r = r_x7;  n_g = '0;    n_b = r_c7;  end
            default: begin n_r = r_c7; n_g = '0;    n_b = r_x7;  end
        endcase
    end

    hsl_chan #(.FRACTION_BITS(F)) u_red (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_comp (n_r),
        .i_m    (r_m7),
        .o_chan (red8)
    );

    hsl_chan #(.FRACTION_BITS(F)) u_grn (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_comp (n_g),
        .i_m    (r_m7),
        .o_chan (grn8)
    );

    hsl_chan #(.FRACTION_BITS(F)) u_blu (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_comp (n_b),
        .i_m    (r_m7),
        .o_chan (blu8)
    );

    // ---------------- stage 9: clamp result into the output register
    logic [OUT_BITS-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out <= {blu8, grn8, red8};
        end
    end

    assign o_m_tdata = r_out;

endmodule

### rtl/hsl_chk.sv
`timescale 1ns / 1ps
// hsl_chk: port-level checks for hsl_to_rgb, attached by bind
// depends on hsl_to_rgb ports only

module hsl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [55:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a stalled result must block new requests
    a_back_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("request taken while output stalled");

    // an empty output stage never blocks the input
    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind hsl_to_rgb hsl_chk u_hsl_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### test/tb_hsl_to_rgb.sv
`timescale 1ns / 1ps
// tb_hsl_to_rgb: self-checking bench for the hsl to rgb converter, directed and random hsl
// requests with stalls on both sides, each pixel checked against a predictor
// depends on hsl_pkg and hsl_to_rgb

module tb_hsl_to_rgb;
    import hsl_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int RANDOM_ITEMS = 750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int FRAC_ONE     = 65536;
    localparam int FRAC_MAX     = 131071;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // expected pixels in request order, plus the predictor that makes them
    class rgb_expectations;
        t_rgb rgb_due_q[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function longint channel_of(longint comp, longint m, longint one);
            longint v;
            v = ((comp + m) * 255) / one;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return v;
        endfunction

        static function t_rgb rgb_of_hsl(logic signed [15:0] hue, logic [16:0] sat,
                                         logic [16:0] lit);
            longint  one, s, l, hw, p, d, w, t, c, x, m, r, g, b;
            t_sector sector;
            t_rgb    pix;
            one = longint'(1) << FRAC_BITS;
            s = longint'(sat);
            l = longint'(lit);
            if (FRAC_BITS >= 16) begin
                s = s << (FRAC_BITS - 16);
                l = l << (FRAC_BITS - 16);
            end else begin
                s = s >> (16 - FRAC_BITS);
                l = l >> (16 - FRAC_BITS);
            end
            hw = longint'(hue) % longint'(HUE_FULL);
            if (hw < 0)
                hw += HUE_FULL;
            sector = t_sector'(hw / HUE_SECTOR);
            p = hw % (2 * HUE_SECTOR);
            d = p - HUE_SECTOR;
            if (d < 0)
                d = -d;
            w = HUE_SECTOR - d;
            t = 2 * l - one;
            if (t < 0)
                t = -t;
            c = ((one - t) * s) / one;
            x = (c * w) / longint'(HUE_SECTOR);
            m = l - c / 2;
            case (sector)
                SEC_RG: begin r = c; g = x; b = 0; end
                SEC_GR: begin r = x; g = c; b = 0; end
                SEC_GB: begin r = 0; g = c; b = x; end
                SEC_BG: begin r = 0; g = x; b = c; end
                SEC_BR: begin r = x; g = 0; b = c; end
                default: begin r = c; g = 0; b = x; end
            endcase
            pix.red   = 8'(channel_of(r, m, one));
            pix.green = 8'(channel_of(g, m, one));
            pix.blue  = 8'(channel_of(b, m, one));
            return pix;
        endfunction

        function void note_request(logic [IN_BITS-1:0] data);
            rgb_due_q.push_back(rgb_of_hsl(data[15:0], data[32:16], data[49:33]));
        endfunction

        function void check_pixel(logic [OUT_BITS-1:0] data);
            t_rgb want;
            if (rgb_due_q.size() == 0) begin
                $error("pixel %h arrived with no request outstanding", data);
                mismatches++;
            end else begin
                want = rgb_due_q.pop_front();
                if (data[7:0] !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, data[7:0]);
                    mismatches++;
                end
                if (data[15:8] !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, data[15:8]);
                    mismatches++;
                end
                if (data[23:16] !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, data[23:16]);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return rgb_due_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    // hue[15:0] saturation[32:16] lightness[49:33], zero pad [55:50]
    logic [IN_BITS-1:0]  i_s_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    // red[7:0] green[15:8] blue[23:16]
    logic [OUT_BITS-1:0] o_m_tdata;

    rgb_expectations sb;
    bit              hold_req;    // asks the pixel sink for one long hold-off
    bit              tx_burst;    // sender offers back to back
    bit              rx_burst;    // sink always ready
    int              idle_count;

    hsl_to_rgb #(
        .FRACTION_BITS(FRAC_BITS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watch both handshakes at the rising edge, inputs are stable by then
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_request(i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                sb.check_pixel(o_m_tdata);
        end
    end

    // watchdog: a run of cycles with no handshake at all that reaches IDLE_LIMIT ends the test
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // offer one hsl request after a random gap (none in a burst), return at the falling edge
    // following its acceptance
    task automatic send_hsl(input logic [15:0] hue, input logic [16:0] sat,
                            input logic [16:0] lit);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= {6'b0, lit, sat, hue};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // fraction with extremes and out-of-range values (above 1.0) mixed in
    function automatic logic [16:0] pick_fraction();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 17'd0;
        else if (roll < 10)
            return 17'(FRAC_ONE);
        else if (roll < 22)
            return 17'($urandom_range(FRAC_ONE + 1, FRAC_MAX));
        else
            return 17'($urandom_range(0, FRAC_ONE));
    endfunction

    // hue with a fair share landing on or next to a sector edge
    function automatic logic [15:0] pick_hue();
        int k;
        if ($urandom_range(0, 99) < 20) begin
            k = $urandom_range(0, 68) - 34;
            return 16'(k * int'(HUE_SECTOR) + int'($urandom_range(0, 4)) - 2);
        end
        return 16'($urandom);
    endfunction

    // pixel sink: random ready gaps, bursts, and one long hold when asked
    initial begin
        int gap;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    // main sequence
    initial begin
        sb = new();
        hold_req   = 1'b0;
        tx_burst   = 1'b0;
        rx_burst   = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: sector edges, hue extremes and wrap, saturation and
        // lightness at zero, one and above one
        send_hsl(16'd0, 17'd0, 17'd0);
        send_hsl(16'd0, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd959, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd960, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd1919, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd1920, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd2880, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd3840, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd4800, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd5759, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'd5760, 17'(FRAC_ONE), 17'd32768);
        // negative hue wraps upward
        send_hsl(16'hFFFF, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'h8000, 17'(FRAC_ONE), 17'd32768);
        send_hsl(16'h7FFF, 17'(FRAC_ONE), 17'd32768);
        // white and black
        send_hsl(16'd480, 17'(FRAC_ONE), 17'(FRAC_ONE));
        send_hsl(16'd480, 17'(FRAC_ONE), 17'd0);
        send_hsl(16'd100, 17'd65535, 17'd65535);
        // above one: chroma can go negative, channels must still clamp
        send_hsl(16'd1000, 17'(FRAC_MAX), 17'(FRAC_MAX));
        send_hsl(16'd2000, 17'(FRAC_MAX), 17'd16384);
        send_hsl(16'd3000, 17'd40000, 17'd100000);
        send_hsl(16'hF000, 17'd98304, 17'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            tx_burst = (i >= 100 && i < 180);
            rx_burst = (i >= 140 && i < 220);
            if (i == 300)
                hold_req = 1'b1;    // sink holds off while requests keep coming
            if (i == 500) begin
                // sender pauses until the pipe has emptied
                i_s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end
            send_hsl(pick_hue(), pick_fraction(), pick_fraction());
        end
        i_s_tvalid <= 1'b0;
        rx_burst = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected pixels never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
